// ----- design/wft_pkg.sv -----
package wft_pkg;

    // Tile geometry and field widths.
    localparam int TILE                = 6;
    localparam int ROW_W               = 3;
    localparam int VALUE_BITS          = 23;
    localparam int COEF_W              = 4;
    localparam int SAMPLE_BITS_DEFAULT = 16;
    localparam int OUT_FIELD_W         = ROW_W + TILE * VALUE_BITS;
    localparam int OUT_DATA_W          = ((OUT_FIELD_W + 7) / 8) * 8;

    localparam logic [ROW_W-1:0] FIRST_ROW = 3'd0;
    localparam logic [ROW_W-1:0] LAST_ROW  = 3'd5;

    typedef logic signed [COEF_W-1:0] coef_t;

    // B^T of the F(4x4,3x3) transform, indexed [row][column].
    localparam coef_t BT_COEF [TILE][TILE] = '{
        '{ 4'sd4,  4'sd0, -4'sd5,  4'sd0, 4'sd1, 4'sd0 },
        '{ 4'sd0, -4'sd4, -4'sd4,  4'sd1, 4'sd1, 4'sd0 },
        '{ 4'sd0,  4'sd4, -4'sd4, -4'sd1, 4'sd1, 4'sd0 },
        '{ 4'sd0, -4'sd2, -4'sd1,  4'sd2, 4'sd1, 4'sd0 },
        '{ 4'sd0,  4'sd2, -4'sd1, -4'sd2, 4'sd1, 4'sd0 },
        '{ 4'sd0,  4'sd4,  4'sd0, -4'sd5, 4'sd0, 4'sd1 }
    };

    typedef enum logic {
        ST_ACCUM,
        ST_EMIT
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic             accum;
        logic [ROW_W-1:0] row_sel;
        logic             load;
        logic [ROW_W-1:0] out_idx;
        logic             clear;
    } wft_cmd_t;

endpackage

// ----- design/wft_ctrl.sv -----
module wft_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_valid,
    output logic             s_ready,
    input  logic             m_ready,
    output logic             m_valid,
    output wft_pkg::wft_cmd_t cmd
);
    import wft_pkg::*;

    state_t           state_reg, state_next;
    logic [ROW_W-1:0] count_reg, count_next;
    logic [ROW_W-1:0] emit_idx_reg, emit_idx_next;
    logic             m_valid_reg, m_valid_next;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_ACCUM;
            count_reg    <= FIRST_ROW;
            emit_idx_reg <= FIRST_ROW;
            m_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            emit_idx_reg <= emit_idx_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    // Next state and datapath commands.
    always_comb
    begin
        state_next    = state_reg;
        count_next    = count_reg;
        emit_idx_next = emit_idx_reg;
        m_valid_next  = m_valid_reg;
        cmd           = '0;
        s_ready       = (state_reg == ST_ACCUM);

        // The output register empties when the receiver takes its item.
        if (m_valid_reg && m_ready)
        begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_ACCUM:
            begin
                if (s_valid)
                begin
                    cmd.accum   = 1'b1;
                    cmd.row_sel = count_reg;
                    if (count_reg == LAST_ROW)
                    begin
                        count_next    = FIRST_ROW;
                        emit_idx_next = FIRST_ROW;
                        state_next    = ST_EMIT;
                    end
                    else
                    begin
                        count_next = count_reg + 1'b1;
                    end
                end
            end
            ST_EMIT:
            begin
                // Load one result row whenever the output register is free.
                if (!m_valid_reg || m_ready)
                begin
                    cmd.load     = 1'b1;
                    cmd.out_idx  = emit_idx_reg;
                    m_valid_next = 1'b1;
                    if (emit_idx_reg == LAST_ROW)
                    begin
                        cmd.clear  = 1'b1;
                        state_next = ST_ACCUM;
                    end
                    else
                    begin
                        emit_idx_next = emit_idx_reg + 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = ST_ACCUM;
            end
        endcase
    end

    assign m_valid = m_valid_reg;

`ifndef NO_ASSERTIONS
    // The sixth row of a tile starts the row pass at result row zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_valid && s_ready && count_reg == LAST_ROW)
        |=> (state_reg == ST_EMIT && emit_idx_reg == FIRST_ROW))
        else $error("row pass did not start after the sixth row");

    // No rows are counted while results are going out.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT) |=> $stable(count_reg))
        else $error("row count moved during the row pass");

    // The partials are cleared only together with the last result row.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.clear |-> (cmd.load && cmd.out_idx == LAST_ROW))
        else $error("partials cleared before the last result row");

    // A loaded result is offered in the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> m_valid_reg)
        else $error("loaded result not offered");
`endif

endmodule

// ----- design/wft_datapath.sv -----
module wft_datapath #(
    parameter int SAMPLE_BITS = wft_pkg::SAMPLE_BITS_DEFAULT
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  wft_pkg::wft_cmd_t                     cmd,
    input  logic [((6*SAMPLE_BITS+7)/8)*8-1:0]    in_data,
    output logic [wft_pkg::OUT_DATA_W-1:0]        out_data,
    output logic                                  out_last
);
    import wft_pkg::*;

    localparam int PART_W = SAMPLE_BITS + 4;
    localparam int SUM_W  = SAMPLE_BITS + 8;
    localparam int EXT_W  = (SUM_W > VALUE_BITS) ? SUM_W : VALUE_BITS;

    logic signed [SAMPLE_BITS-1:0] samp [TILE];
    logic signed [PART_W-1:0]      part_reg  [TILE][TILE];
    logic signed [PART_W-1:0]      part_next [TILE][TILE];
    logic signed [PART_W-1:0]      sel_row [TILE];
    logic signed [SUM_W-1:0]       vsum [TILE];
    logic signed [EXT_W-1:0]       vext [TILE];
    logic signed [VALUE_BITS-1:0]  val_reg [TILE];
    logic [ROW_W-1:0]              idx_reg;
    logic                          last_reg;

    // Multiply by one transform coefficient using shifts and adds.
    function automatic logic signed [SUM_W-1:0] scale(
        input coef_t                   k,
        input logic signed [SUM_W-1:0] x
    );
        logic signed [SUM_W-1:0] r;
        case (k)
            4'sd1:   r = x;
            -4'sd1:  r = -x;
            4'sd2:   r = x <<< 1;
            -4'sd2:  r = -(x <<< 1);
            4'sd4:   r = x <<< 2;
            -4'sd4:  r = -(x <<< 2);
            -4'sd5:  r = -((x <<< 2) + x);
            default: r = '0;
        endcase
        return r;
    endfunction

    // Split the incoming row into samples.
    always_comb
    begin
        for (int c = 0; c < TILE; c++)
        begin
            samp[c] = in_data[c*SAMPLE_BITS +: SAMPLE_BITS];
        end
    end

    // Column pass: fold the row into all 36 partials at once.
    always_comb
    begin
        for (int i = 0; i < TILE; i++)
        begin
            for (int c = 0; c < TILE; c++)
            begin
                part_next[i][c] = part_reg[i][c];
                if (cmd.clear)
                begin
                    part_next[i][c] = '0;
                end
                else if (cmd.accum)
                begin
                    part_next[i][c] = part_reg[i][c]
                        + PART_W'(scale(BT_COEF[i][cmd.row_sel], SUM_W'(samp[c])));
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < TILE; i++)
            begin
                for (int c = 0; c < TILE; c++)
                begin
                    part_reg[i][c] <= '0;
                end
            end
        end
        else
        begin
            part_reg <= part_next;
        end
    end

    // Row pass on the selected partial row.
    always_comb
    begin
        for (int c = 0; c < TILE; c++)
        begin
            sel_row[c] = part_reg[cmd.out_idx][c];
        end
        for (int j = 0; j < TILE; j++)
        begin
            vsum[j] = '0;
            for (int c = 0; c < TILE; c++)
            begin
                vsum[j] = vsum[j] + scale(BT_COEF[j][c], SUM_W'(sel_row[c]));
            end
            vext[j] = EXT_W'(vsum[j]);
        end
    end

    // Output register; results wrap to the value width.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            for (int j = 0; j < TILE; j++)
            begin
                val_reg[j] <= vext[j][VALUE_BITS-1:0];
            end
            idx_reg  <= cmd.out_idx;
            last_reg <= (cmd.out_idx == LAST_ROW);
        end
    end

    // Pack the result: row index first, then the six values.
    always_comb
    begin
        out_data            = '0;
        out_data[ROW_W-1:0] = idx_reg;
        for (int j = 0; j < TILE; j++)
        begin
            out_data[ROW_W + j*VALUE_BITS +: VALUE_BITS] = val_reg[j];
        end
    end

    assign out_last = last_reg;

endmodule

// ----- design/winograd_f4x3_input_transform_unit.sv -----
// Winograd F(4x4,3x3) input transform, V = B^T d B, on one 6x6 tile.
//
// Input channel (s_*): one item is one tile row of six signed samples,
// rows 0 to 5 of a tile in order. Each accepted row is folded into 36
// column partials as it is accepted.
// Output channel (m_*): after the sixth row the block sends six items,
// result rows 0 to 5, each with its row index and six 23-bit values;
// m_tlast marks row 5. Values that exceed 23 bits wrap.
//
// The first result row is offered once the controller has entered its emit
// state and loaded that row into the output register. Rows are taken one
// per cycle while the block accumulates; while the six result rows leave
// through the single output register the input is held off.
// When the receiver stalls, the output register holds its item and the
// row pass waits; no result is lost.
// Reset clears the partials, the row count and the output valid flag;
// the block is ready for row 0 of a new tile right after reset.
module winograd_f4x3_input_transform_unit #(
    parameter int SAMPLE_BITS = wft_pkg::SAMPLE_BITS_DEFAULT
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // sample_0 .. sample_5, zero padded to whole bytes
    input  logic [((6*SAMPLE_BITS+7)/8)*8-1:0] s_tdata,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // row_index, value_0 .. value_5, zero padded to whole bytes
    output logic [wft_pkg::OUT_DATA_W-1:0]     m_tdata,
    output logic                               m_tlast
);
    import wft_pkg::*;

    wft_cmd_t cmd;

    wft_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_valid (s_tvalid),
        .s_ready (s_tready),
        .m_ready (m_tready),
        .m_valid (m_tvalid),
        .cmd     (cmd)
    );

    wft_datapath #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .in_data  (s_tdata),
        .out_data (m_tdata),
        .out_last (m_tlast)
    );

endmodule
